>>> hw/rtl/orb_pkg.sv
// Shared types, register indexes and defaults of the overwriting ring buffer / ROM store.
package orb_pkg;

	localparam int DEPTH_DEF = 256;
	localparam int DATA_W_DEF = 32;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int PERIOD_W = 16;
	localparam int USED_W = 9;
	// stored word and item payload width
	localparam int WORD_W = DATA_W_DEF;
	localparam int ADDR_W = 8;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_LOAD  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROM_MODE      = 2'd0,
		REG_ACCESS_PERIOD = 2'd1,
		REG_USED_SIZE     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		op_t                       op;
		logic signed [WORD_W-1:0]  data_in;
		logic [ADDR_W-1:0]         load_addr;
	} in_t;

	typedef struct packed {
		logic signed [WORD_W-1:0]  data_out;
		logic                      data_valid;
		logic                      window_open;
		logic                      write_dropped;
	} out_t;

	// status of one item on its way from the control logic to the result register
	typedef struct packed {
		logic data_valid;
		logic window_open;
		logic write_dropped;
	} meta_t;

endpackage

>>> hw/rtl/overwrite_ring_buffer_or_rom.sv
// Top level: item handshake, memory read stage and result register.
//
// Overwriting ring buffer / sequential ROM store. Items (tick, source write,
// read, preload) are taken one per clock cycle sustained while no clearing
// sweep runs and the result path is not stalled; each gives one result via
// the store's registered read port followed by the result register. Pointer and
// tick state sit in flip-flops and are updated in the accept cycle, so a
// read directly after a write or preload already sees the new word. After
// reset the store is cleared to zero by a sweep over its DEPTH entries, one
// entry per cycle, during which no item is accepted; configuration writes are
// taken at any time (cfg_ready is always high) and should only be issued
// while the block is idle.
module overwrite_ring_buffer_or_rom #(
	parameter int DEPTH = orb_pkg::DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [orb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [orb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  orb_pkg::in_t                   item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output orb_pkg::out_t                  result
);

	localparam int AW = $clog2(DEPTH);

	logic                       accept;
	logic                       busy;
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr, mem_raddr;
	logic [orb_pkg::WORD_W-1:0] mem_wdata, mem_rdata;
	orb_pkg::meta_t             meta;
	orb_pkg::meta_t             meta_s1;
	logic                       valid_s1;
	logic                       move_s1;
	logic                       result_valid_q;
	orb_pkg::out_t              result_q;

	assign cfg_ready = 1'b1;
	assign move_s1 = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !busy && (!valid_s1 || move_s1);
	assign accept = item_valid && item_ready;

	orb_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.item     (item),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.meta     (meta)
	);

	orb_store #(
		.DEPTH (DEPTH),
		.DATA_W(orb_pkg::WORD_W)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (mem_raddr),
		.rdata (mem_rdata),
		.busy  (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta;
		end
	end

	// zero the word unless the read returned an entry
	always_ff @(posedge clk) begin
		if (move_s1) begin
			result_q.data_out <= meta_s1.data_valid ? mem_rdata : '0;
			result_q.data_valid <= meta_s1.data_valid;
			result_q.window_open <= meta_s1.window_open;
			result_q.write_dropped <= meta_s1.write_dropped;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

>>> hw/rtl/orb_store.sv
// Word store: synchronous single-port-write, registered-read memory with a clearing sweep.
module orb_store #(
	parameter int DEPTH = orb_pkg::DEPTH_DEF,
	parameter int DATA_W = orb_pkg::DATA_W_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata,
	output logic              busy
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic              clr_q;
	logic [AW-1:0]     clr_addr_q;

	// sweep zeros through every entry after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

	assign busy = clr_q;

endmodule

>>> hw/rtl/orb_ctrl.sv
// Configuration registers, head/tail/full pointers and tick window logic.
module orb_ctrl #(
	parameter int DEPTH = orb_pkg::DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr,
	input  logic [orb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [orb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            accept,
	input  orb_pkg::in_t                    item,
	output logic                            mem_we,
	output logic [AW-1:0]                   mem_waddr,
	output logic [orb_pkg::WORD_W-1:0]      mem_wdata,
	output logic [AW-1:0]                   mem_raddr,
	output orb_pkg::meta_t                  meta
);

	localparam int SZ_MAX = (DEPTH < 511) ? DEPTH : 511;
	localparam int IW = $clog2(SZ_MAX + 1);

	logic                          rom_mode_q;
	logic [orb_pkg::PERIOD_W-1:0]  period_q;
	logic [orb_pkg::USED_W-1:0]    used_q;
	logic [IW-1:0]                 head_q, tail_q;
	logic                          full_q;
	logic [orb_pkg::PERIOD_W-1:0]  tick_q;
	logic                          win_q;

	logic [IW-1:0]                 head_n, tail_n;
	logic                          full_n;
	logic [orb_pkg::PERIOD_W-1:0]  tick_n;
	logic                          win_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_mode_q <= 1'b0;
			period_q <= orb_pkg::PERIOD_W'(1);
			used_q <= orb_pkg::USED_W'(256);
		end else if (cfg_wr) begin
			case (orb_pkg::cfg_reg_t'(cfg_index))
				orb_pkg::REG_ROM_MODE: rom_mode_q <= cfg_data[0];
				orb_pkg::REG_ACCESS_PERIOD: period_q <= cfg_data;
				orb_pkg::REG_USED_SIZE: used_q <= cfg_data[orb_pkg::USED_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [IW-1:0]                size;
		logic [IW-1:0]                head_f, tail_f, head_inc, tail_inc;
		logic [orb_pkg::PERIOD_W-1:0] c;

		// used size zero acts as one, above the depth as the depth
		if (used_q == '0) begin
			size = IW'(1);
		end else if (32'(used_q) > SZ_MAX) begin
			size = IW'(SZ_MAX);
		end else begin
			size = IW'(used_q);
		end

		// reset stale indices left by a size change or mode switch
		head_f = (head_q >= size) ? '0 : head_q;
		tail_f = (tail_q >= size) ? '0 : tail_q;
		head_inc = (head_f + IW'(1) == size) ? '0 : head_f + IW'(1);
		tail_inc = (tail_f + IW'(1) == size) ? '0 : tail_f + IW'(1);
		c = tick_q + orb_pkg::PERIOD_W'(1);

		head_n = head_q;
		tail_n = tail_q;
		full_n = full_q;
		tick_n = tick_q;
		win_n = win_q;
		mem_we = 1'b0;
		mem_waddr = AW'(tail_f);
		mem_wdata = $unsigned(item.data_in);
		mem_raddr = AW'(head_f);
		meta = '0;

		case (item.op)
			orb_pkg::OP_TICK: begin
				if (c >= period_q) begin
					tick_n = '0;
					win_n = 1'b1;
				end else begin
					tick_n = c;
					win_n = 1'b0;
				end
			end
			orb_pkg::OP_WRITE: begin
				if (rom_mode_q || !win_q) begin
					meta.write_dropped = 1'b1;
				end else begin
					mem_we = 1'b1;
					tail_n = tail_inc;
					head_n = full_q ? head_inc : head_f;
					if (tail_inc == (full_q ? head_inc : head_f)) begin
						full_n = 1'b1;
					end
				end
			end
			orb_pkg::OP_READ: begin
				if (rom_mode_q) begin
					// step without wrap; one miss past the end rewinds
					mem_raddr = AW'(head_q);
					if (head_q >= size) begin
						head_n = '0;
					end else begin
						meta.data_valid = 1'b1;
						head_n = head_q + IW'(1);
					end
				end else begin
					head_n = head_f;
					tail_n = tail_f;
					if (full_q || head_f != tail_f) begin
						meta.data_valid = 1'b1;
						head_n = head_inc;
						full_n = 1'b0;
					end
				end
			end
			orb_pkg::OP_LOAD: begin
				mem_waddr = AW'(item.load_addr);
				mem_we = 32'(item.load_addr) < DEPTH;
			end
			default: ;
		endcase

		meta.window_open = win_n;
		mem_we = mem_we & accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			full_q <= 1'b0;
			tick_q <= '0;
			win_q <= 1'b0;
		end else if (accept) begin
			head_q <= head_n;
			tail_q <= tail_n;
			full_q <= full_n;
			tick_q <= tick_n;
			win_q <= win_n;
		end
	end

endmodule

>>> hw/rtl/orb_checker.sv
// Port-level assertions for the store, bound to the top level.
module orb_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          result_valid,
	input logic          result_ready,
	input orb_pkg::out_t result
);

	// hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.data_valid |-> result.data_out == '0)
		else $error("data_out not zero on a miss");

	a_read_or_drop: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.data_valid && result.write_dropped))
		else $error("one item both read and dropped");

endmodule

bind overwrite_ring_buffer_or_rom orb_checker u_orb_checker (.*);
